// ===== hw/rtl/trifn_pkg.sv =====
package trifn_pkg;

  localparam int unsigned CoordW = 16;             // Q8.8 vertex coordinate
  localparam int unsigned EdgeW  = CoordW + 1;     // edge vector component
  localparam int unsigned ProdW  = 2 * EdgeW;      // edge product
  localparam int unsigned CrossW = ProdW + 1;      // cross product component
  localparam int unsigned MagW   = ProdW;          // |cross| fits in 34 bits
  localparam int unsigned HalfW  = MagW / 2;       // magnitude split for squaring
  localparam int unsigned SqW    = 2 * MagW;       // squared magnitude and S
  localparam int unsigned QuoW   = 31;             // floor(2^30 * m^2 / S) <= 2^30
  localparam int unsigned RootW  = 16;             // isqrt of quotient <= 32768
  localparam int unsigned RsqW   = 2 * RootW + 1;  // trial square
  localparam int unsigned NormW  = 16;             // Q1.14 output
  localparam int unsigned Lanes  = 3;

  localparam int unsigned FrontStages = 6;
  localparam int unsigned DivStages   = QuoW;
  localparam int unsigned SqrtStages  = RootW;
  localparam int unsigned NumStages   = FrontStages + DivStages + SqrtStages;

  typedef struct packed {
    logic [Lanes-1:0][SqW-1:0]  rem;
    logic [Lanes-1:0][QuoW-1:0] quo;
    logic [SqW-1:0]             s;
    logic [Lanes-1:0]           neg;
    logic                       zero;
  } div_t;

  typedef struct packed {
    logic [Lanes-1:0][QuoW-1:0]  rad;
    logic [Lanes-1:0][RootW-1:0] root;
    logic [Lanes-1:0][RsqW-1:0]  rsq;
    logic [Lanes-1:0]            neg;
    logic                        zero;
  } sqr_t;

endpackage

// ===== hw/rtl/triangle_flat_normal_unit.sv =====
// Pipeline: 53 pipeline stages from input transfer, then the output register; the
//   stages hold while the last one is full and the output register is full and stalled.
// Throughput: one triangle per cycle while the output is not stalled; set by the per-bit
//   divider and square root stages, each of which holds one triangle.
// Reset: rst_ni clears all stage valid bits and the output valid asynchronously.
module triangle_flat_normal_unit import trifn_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [CoordW-1:0] ax_i,
  input  logic signed [CoordW-1:0] ay_i,
  input  logic signed [CoordW-1:0] az_i,
  input  logic signed [CoordW-1:0] bx_i,
  input  logic signed [CoordW-1:0] by_coord_i,
  input  logic signed [CoordW-1:0] bz_i,
  input  logic signed [CoordW-1:0] cx_i,
  input  logic signed [CoordW-1:0] cy_i,
  input  logic signed [CoordW-1:0] cz_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [NormW-1:0]  norm_x_o,
  output logic signed [NormW-1:0]  norm_y_o,
  output logic signed [NormW-1:0]  norm_z_o
);

  logic [NumStages-1:0] v_q, v_d;
  logic                 pipe_en;
  logic                 out_valid_q;

  // Advance whenever the last stage is empty or the output register can take it.
  assign pipe_en    = !v_q[NumStages-1] || !out_valid_q || !out_stall_i;
  assign in_stall_o = !pipe_en;
  assign v_d        = {v_q[NumStages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (pipe_en) begin
      v_q <= v_d;
    end
  end

  // ---------------- front end: edges, cross product, squares, S
  logic signed [CoordW-1:0] pa [Lanes], pb [Lanes], pc [Lanes];
  assign pa[0] = ax_i; assign pa[1] = ay_i;       assign pa[2] = az_i;
  assign pb[0] = bx_i; assign pb[1] = by_coord_i; assign pb[2] = bz_i;
  assign pc[0] = cx_i; assign pc[1] = cy_i;       assign pc[2] = cz_i;

  logic signed [EdgeW-1:0]  u_q [Lanes], v_edge_q [Lanes];
  logic signed [ProdW-1:0]  pl_q [Lanes], pr_q [Lanes];
  logic signed [CrossW-1:0] n_q [Lanes];
  logic [ProdW-1:0]         hh_q [Lanes], hl_q [Lanes], ll_q [Lanes];
  logic [Lanes-1:0]         neg4_q, neg5_q, neg6_q;
  logic [SqW-1:0]           m2_5_q [Lanes], m2_6_q [Lanes];
  logic [SqW-1:0]           s_q;

  for (genvar i = 0; i < Lanes; i++) begin : g_front
    localparam int unsigned I1 = (i + 1) % Lanes;
    localparam int unsigned I2 = (i + 2) % Lanes;
    logic signed [EdgeW-1:0]  u_d, ve_d;
    logic signed [ProdW-1:0]  pl_d, pr_d;
    logic signed [CrossW-1:0] n_d, nn;
    logic [MagW-1:0]          mag;
    logic [HalfW-1:0]         mh, ml;
    logic [SqW-1:0]           m2_d;

    assign u_d  = {pb[i][CoordW-1], pb[i]} - {pa[i][CoordW-1], pa[i]};
    assign ve_d = {pc[i][CoordW-1], pc[i]} - {pa[i][CoordW-1], pa[i]};
    assign pl_d = u_q[I1] * v_edge_q[I2];
    assign pr_d = u_q[I2] * v_edge_q[I1];
    assign n_d  = pl_q[i] - pr_q[i];
    assign nn   = -n_q[i];
    assign mag  = n_q[i][CrossW-1] ? nn[MagW-1:0] : n_q[i][MagW-1:0];
    assign mh   = mag[MagW-1:HalfW];
    assign ml   = mag[HalfW-1:0];
    // m^2 = hh*2^34 + 2*hl*2^17 + ll
    assign m2_d = {hh_q[i], {MagW{1'b0}}}
                + {{(SqW-ProdW-HalfW-1){1'b0}}, hl_q[i], {(HalfW+1){1'b0}}}
                + {{(SqW-ProdW){1'b0}}, ll_q[i]};

    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        u_q[i]      <= u_d;
        v_edge_q[i] <= ve_d;
        pl_q[i]     <= pl_d;
        pr_q[i]     <= pr_d;
        n_q[i]      <= n_d;
        hh_q[i]     <= mh * mh;
        hl_q[i]     <= mh * ml;
        ll_q[i]     <= ml * ml;
        neg4_q[i]   <= n_q[i][CrossW-1];
        m2_5_q[i]   <= m2_d;
        neg5_q[i]   <= neg4_q[i];
        m2_6_q[i]   <= m2_5_q[i];
        neg6_q[i]   <= neg5_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s_q <= m2_5_q[0] + m2_5_q[1] + m2_5_q[2];
    end
  end

  // ---------------- restoring divider: quotient = floor(2^30 * m^2 / S), one bit a stage
  div_t div_q [DivStages];
  div_t div_d [DivStages];

  for (genvar k = 0; k < DivStages; k++) begin : g_div
    for (genvar i = 0; i < Lanes; i++) begin : g_lane
      logic [SqW:0] part, diff;
      logic         ge;
      if (k == 0) begin : g_first
        assign part = {1'b0, m2_6_q[i]};
        assign diff = part - {1'b0, s_q};
        assign ge   = part >= {1'b0, s_q};
        assign div_d[k].quo[i] = {{(QuoW-1){1'b0}}, ge};
      end else begin : g_next
        assign part = {div_q[k-1].rem[i], 1'b0};
        assign diff = part - {1'b0, div_q[k-1].s};
        assign ge   = part >= {1'b0, div_q[k-1].s};
        assign div_d[k].quo[i] = {div_q[k-1].quo[i][QuoW-2:0], ge};
      end
      assign div_d[k].rem[i] = ge ? diff[SqW-1:0] : part[SqW-1:0];
    end
    if (k == 0) begin : g_side0
      assign div_d[k].s    = s_q;
      assign div_d[k].neg  = neg6_q;
      assign div_d[k].zero = (s_q == '0);
    end else begin : g_side
      assign div_d[k].s    = div_q[k-1].s;
      assign div_d[k].neg  = div_q[k-1].neg;
      assign div_d[k].zero = div_q[k-1].zero;
    end
    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        div_q[k] <= div_d[k];
      end
    end
  end

  // ---------------- square root of the quotient, one root bit a stage
  sqr_t sqr_q [SqrtStages];
  sqr_t sqr_d [SqrtStages];
  sqr_t sqr_in;

  for (genvar i = 0; i < Lanes; i++) begin : g_sqin
    assign sqr_in.rad[i]  = div_q[DivStages-1].quo[i];
    assign sqr_in.root[i] = '0;
    assign sqr_in.rsq[i]  = '0;
  end
  assign sqr_in.neg  = div_q[DivStages-1].neg;
  assign sqr_in.zero = div_q[DivStages-1].zero;

  for (genvar t = 0; t < SqrtStages; t++) begin : g_sqrt
    localparam int unsigned B = RootW - 1 - t;
    sqr_t src;
    if (t == 0) begin : g_src0
      assign src = sqr_in;
    end else begin : g_srcn
      assign src = sqr_q[t-1];
    end
    for (genvar i = 0; i < Lanes; i++) begin : g_lane
      logic [RsqW-1:0] incr, trial;
      logic            fits;
      // (j + 2^B)^2 = j^2 + j*2^(B+1) + 2^(2B); bits of j at B and below are clear
      assign incr  = ({{(RsqW-RootW){1'b0}}, src.root[i]} << (B + 1))
                   | (RsqW'(1) << (2 * B));
      assign trial = src.rsq[i] + incr;
      assign fits  = trial <= {{(RsqW-QuoW){1'b0}}, src.rad[i]};
      assign sqr_d[t].rad[i]  = src.rad[i];
      assign sqr_d[t].root[i] = fits ? (src.root[i] | (RootW'(1) << B)) : src.root[i];
      assign sqr_d[t].rsq[i]  = fits ? trial : src.rsq[i];
    end
    assign sqr_d[t].neg  = src.neg;
    assign sqr_d[t].zero = src.zero;
    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        sqr_q[t] <= sqr_d[t];
      end
    end
  end

  // ---------------- rounding, sign and output register
  logic [NormW-1:0] norm_d [Lanes];
  logic [NormW-1:0] norm_q [Lanes];
  logic             out_load;

  for (genvar i = 0; i < Lanes; i++) begin : g_out
    logic [RootW:0]   inc;
    logic [NormW-1:0] r;
    // largest odd k <= j gives r = (j + 1) / 2
    assign inc = {1'b0, sqr_q[SqrtStages-1].root[i]} + (RootW+1)'(1);
    assign r   = inc[RootW:1];
    assign norm_d[i] = sqr_q[SqrtStages-1].zero ? '0
                     : (sqr_q[SqrtStages-1].neg[i] ? -r : r);
  end

  assign out_load = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= v_q[NumStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      norm_q[0] <= norm_d[0];
      norm_q[1] <= norm_d[1];
      norm_q[2] <= norm_d[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign norm_x_o    = norm_q[0];
  assign norm_y_o    = norm_q[1];
  assign norm_z_o    = norm_q[2];

  // ---------------- assertions
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(v_q))
    else $error("pipeline valid bits moved while stalled");

  // A degenerate triangle divides by zero; its quotient and root are dropped.
  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[FrontStages+DivStages-1] && !div_q[DivStages-1].zero) |->
      (div_q[DivStages-1].quo[0] <= (QuoW'(1) << (QuoW-1)) &&
       div_q[DivStages-1].quo[1] <= (QuoW'(1) << (QuoW-1)) &&
       div_q[DivStages-1].quo[2] <= (QuoW'(1) << (QuoW-1))))
    else $error("quotient above 2^30");

  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NumStages-1] && !sqr_q[SqrtStages-1].zero) |->
      (sqr_q[SqrtStages-1].root[0] <= (RootW'(1) << (RootW-1)) &&
       sqr_q[SqrtStages-1].root[1] <= (RootW'(1) << (RootW-1)) &&
       sqr_q[SqrtStages-1].root[2] <= (RootW'(1) << (RootW-1))))
    else $error("root above 32768");

  a_out_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (norm_x_o <= 16'sd16384 && norm_x_o >= -16'sd16384 &&
       norm_y_o <= 16'sd16384 && norm_y_o >= -16'sd16384 &&
       norm_z_o <= 16'sd16384 && norm_z_o >= -16'sd16384))
    else $error("normal component outside unit range");

endmodule

// ===== tb/sv/tb_triangle_flat_normal_unit.sv =====
module tb_triangle_flat_normal_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import trifn_pkg::*;

  localparam int unsigned LatencyCycles = 54;
  localparam logic [15:0] NormOne = 16'd16384;

  typedef struct {
    logic signed [CoordW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  } tri_t;

  typedef struct {
    logic signed [NormW-1:0] nx, ny, nz;
  } normal_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic signed [CoordW-1:0] ax_i, ay_i, az_i, bx_i, by_coord_i, bz_i, cx_i, cy_i, cz_i;
  logic out_valid_o;
  logic out_stall_i;
  logic signed [NormW-1:0] norm_x_o, norm_y_o, norm_z_o;

  normal_t normal_q[$];
  int unsigned error_cnt;
  bit send_gaps;
  bit recv_stalls;

  triangle_flat_normal_unit uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .ax_i, .ay_i, .az_i, .bx_i, .by_coord_i, .bz_i, .cx_i, .cy_i, .cz_i,
    .out_valid_o, .out_stall_i, .norm_x_o, .norm_y_o, .norm_z_o
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Rounded Q1.14 component: largest r with (2r-1)^2 * S <= (2^15 * |c|)^2.
  function automatic logic [NormW-1:0] unit_component(longint c, logic [127:0] s);
    logic [127:0] mag;
    logic [127:0] rhs;
    logic [127:0] k;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] mid;
    mag = (c < 0) ? 128'(-c) : 128'(c);
    rhs = (mag << 15) * (mag << 15);
    lo = 16'd0;
    hi = NormOne;
    while (lo < hi) begin
      mid = (lo + hi + 16'd1) >> 1;
      k = 128'(2 * mid - 1);
      if (s * k * k <= rhs) begin
        lo = mid;
      end else begin
        hi = mid - 16'd1;
      end
    end
    return (c < 0) ? -lo : lo;
  endfunction

  function automatic normal_t face_normal(tri_t t);
    longint ux, uy, uz, vx, vy, vz, nx, ny, nz;
    logic [127:0] mx, my, mz, s;
    normal_t r;
    ux = longint'(t.bx) - longint'(t.ax);
    uy = longint'(t.by) - longint'(t.ay);
    uz = longint'(t.bz) - longint'(t.az);
    vx = longint'(t.cx) - longint'(t.ax);
    vy = longint'(t.cy) - longint'(t.ay);
    vz = longint'(t.cz) - longint'(t.az);
    nx = uy * vz - uz * vy;
    ny = uz * vx - ux * vz;
    nz = ux * vy - uy * vx;
    mx = (nx < 0) ? 128'(-nx) : 128'(nx);
    my = (ny < 0) ? 128'(-ny) : 128'(ny);
    mz = (nz < 0) ? 128'(-nz) : 128'(nz);
    s = mx * mx + my * my + mz * mz;
    if (s == 0) begin
      r.nx = '0;
      r.ny = '0;
      r.nz = '0;
    end else begin
      r.nx = unit_component(nx, s);
      r.ny = unit_component(ny, s);
      r.nz = unit_component(nz, s);
    end
    return r;
  endfunction

  task automatic send_triangle(tri_t t);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ax_i <= t.ax; ay_i <= t.ay; az_i <= t.az;
    bx_i <= t.bx; by_coord_i <= t.by; bz_i <= t.bz;
    cx_i <= t.cx; cy_i <= t.cy; cz_i <= t.cz;
    do @(posedge clk_i); while (in_stall_o);
    normal_q.insert(normal_q.size(), face_normal(t));
  endtask

  function automatic tri_t tri_of(int a0, int a1, int a2, int b0, int b1, int b2,
                                  int c0, int c1, int c2);
    tri_t t;
    t.ax = 16'(a0); t.ay = 16'(a1); t.az = 16'(a2);
    t.bx = 16'(b0); t.by = 16'(b1); t.bz = 16'(b2);
    t.cx = 16'(c0); t.cy = 16'(c1); t.cz = 16'(c2);
    return t;
  endfunction

  function automatic logic signed [15:0] rand_coord(int unsigned span);
    if (span == 0) return 16'($urandom);
    return 16'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic tri_t rand_tri(int unsigned span);
    tri_t t;
    t.ax = rand_coord(span); t.ay = rand_coord(span); t.az = rand_coord(span);
    t.bx = rand_coord(span); t.by = rand_coord(span); t.bz = rand_coord(span);
    t.cx = rand_coord(span); t.cy = rand_coord(span); t.cz = rand_coord(span);
    return t;
  endfunction

  task automatic test_directed();
    send_triangle(tri_of(0, 0, 0, 256, 0, 0, 0, 256, 0));
    send_triangle(tri_of(0, 0, 0, 0, 256, 0, 256, 0, 0));
    send_triangle(tri_of(0, 0, 0, 0, 256, 0, 0, 0, 256));
    send_triangle(tri_of(0, 0, 0, 0, 0, 256, 256, 0, 0));
    send_triangle(tri_of(0, 0, 0, 1, 0, 0, 0, 1, 0));
    send_triangle(tri_of(-32768, -32768, -32768, 32767, -32768, -32768,
                         -32768, 32767, -32768));
    send_triangle(tri_of(32767, 32767, 32767, -32768, 32767, 32767,
                         32767, -32768, 32767));
    send_triangle(tri_of(-32768, -32768, -32768, 32767, 32767, -32768,
                         32767, -32768, 32767));
    send_triangle(tri_of(32767, -32768, 32767, -32768, 32767, -32768,
                         -32768, -32768, 32767));
    send_triangle(tri_of(1, 2, 3, 1, 2, 3, 1, 2, 3));
    send_triangle(tri_of(-32768, -32768, -32768, -32768, -32768, -32768,
                         -32768, -32768, -32768));
    send_triangle(tri_of(0, 0, 0, 100, 200, 300, 200, 400, 600));
    send_triangle(tri_of(-32768, 0, 0, 32767, 0, 0, 0, 0, 0));
    send_triangle(tri_of(0, 0, 0, 256, 256, 0, 0, 0, 256));
    send_triangle(tri_of(0, 0, 0, 256, 0, 0, 0, 256, 256));
    send_triangle(tri_of(0, 0, 0, 3, 0, 0, 0, 4, 1));
    send_triangle(tri_of(0, 0, 0, 1, 1, 0, 0, 1, 1));
    send_triangle(tri_of(5, -7, 9, 6, -7, 9, 5, -6, 10));
  endtask

  task automatic test_random_full(int unsigned n);
    repeat (n) send_triangle(rand_tri(0));
  endtask

  task automatic test_random_small(int unsigned n);
    repeat (n) send_triangle(rand_tri($urandom_range(1, 8)));
  endtask

  // Build collinear and coincident triangles from random points.
  task automatic test_degenerate(int unsigned n);
    tri_t t;
    int dx, dy, dz;
    repeat (n) begin
      t = rand_tri(5000);
      dx = int'(t.bx) - int'(t.ax);
      dy = int'(t.by) - int'(t.ay);
      dz = int'(t.bz) - int'(t.az);
      t.cx = 16'(int'(t.ax) + 2 * dx);
      t.cy = 16'(int'(t.ay) + 2 * dy);
      t.cz = 16'(int'(t.az) + 2 * dz);
      if ($urandom_range(0, 1)) begin
        t.bx = t.ax;
        t.by = t.ay;
        t.bz = t.az;
      end
      send_triangle(t);
    end
  endtask

  task automatic test_drain_pause();
    in_valid_i <= 1'b0;
    wait (normal_q.size() == 0);
    @(posedge clk_i);
  endtask

  // Stall the result side in random bursts while enabled.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (recv_stalls && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    normal_t exp_n;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (normal_q.size() == 0) begin
        $display("%0t: result with no triangle pending: %0d %0d %0d",
                 $time, norm_x_o, norm_y_o, norm_z_o);
        error_cnt++;
      end else begin
        exp_n = normal_q.pop_front();
        if (norm_x_o !== exp_n.nx) begin
          $display("%0t: norm_x expected %0d actual %0d", $time, exp_n.nx, norm_x_o);
          error_cnt++;
        end
        if (norm_y_o !== exp_n.ny) begin
          $display("%0t: norm_y expected %0d actual %0d", $time, exp_n.ny, norm_y_o);
          error_cnt++;
        end
        if (norm_z_o !== exp_n.nz) begin
          $display("%0t: norm_z expected %0d actual %0d", $time, exp_n.nz, norm_z_o);
          error_cnt++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("tb_triangle_flat_normal_unit failed");
    $finish;
  end

  initial begin
    error_cnt = 0;
    send_gaps = 1'b1;
    recv_stalls = 1'b1;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    {ax_i, ay_i, az_i, bx_i, by_coord_i, bz_i, cx_i, cy_i, cz_i} = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_full(300);
    test_drain_pause();
    test_random_small(150);
    test_degenerate(60);
    test_random_full(150);
    // Final stretch runs back to back with no stalls.
    in_valid_i <= 1'b0;
    send_gaps = 1'b0;
    recv_stalls = 1'b0;
    repeat (20) @(posedge clk_i);
    test_random_full(140);
    in_valid_i <= 1'b0;
    wait (normal_q.size() == 0);
    repeat (LatencyCycles + 10) @(posedge clk_i);
    if (error_cnt == 0 && normal_q.size() == 0) begin
      $display("tb_triangle_flat_normal_unit passed");
    end else begin
      $display("tb_triangle_flat_normal_unit failed");
    end
    $finish;
  end

endmodule
